[rtl/core/mmbf_pkg.sv]
// shared types, constants and lane arithmetic for the 2x2 box-filter mip generator
// no dependencies; imported by every module of the block
`default_nettype none

package mmbf_pkg;

	// image limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_LEVELS = 11;

	// field widths
	localparam int DIM_W   = 11;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int POS_W   = 9;
	localparam int LVL_W   = 4;
	localparam int PIX_W   = 32;
	localparam int PSUM_W  = 36;
	localparam int CIDX_W  = 2;

	// line buffer: every level's pair sums packed back to back
	localparam int LB_DEPTH = MAX_WIDTH - 1;
	localparam int LB_AW    = $clog2(MAX_WIDTH);

	// register reset values
	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1024);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1024);

	typedef enum logic [CIDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RGBA   = 2'd2,
		REG_NORMAL = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_AVG
	} ctrl_state_t;

	// effective configuration seen by the sequencer
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [LVL_W-1:0] levels;
		logic             rgba;
		logic             nrm;
	} cfg_t;

	// line buffer access
	typedef struct packed {
		logic              we;
		logic              re;
		logic [LB_AW-1:0]  addr;
		logic [PSUM_W-1:0] wdata_c;
		logic [PSUM_W-1:0] wdata_n;
	} lb_req_t;

	// clamp a raw dimension register into 1..max
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw,
			input logic [DIM_W-1:0] max_v);
		logic [DIM_W-1:0] v;
		v = raw;
		if (v == '0) v = DIM_W'(1);
		if (v > max_v) v = max_v;
		return v;
	endfunction

	// floor(log2(w)) + 1, capped at the level limit
	function automatic logic [LVL_W-1:0] level_count(input logic [DIM_W-1:0] w);
		logic [LVL_W-1:0] n;
		n = LVL_W'(1);
		for (int i = 1; i < DIM_W; i++) begin
			if ((w >> i) != '0) n = LVL_W'(i + 1);
		end
		if (n > LVL_W'(MAX_LEVELS)) n = LVL_W'(MAX_LEVELS);
		return n;
	endfunction

	// first line buffer entry of a level
	function automatic logic [LB_AW-1:0] lb_base(input logic [LVL_W-1:0] lv);
		logic [DIM_W-1:0] mw;
		logic [DIM_W-1:0] b;
		mw = DIM_W'(MAX_WIDTH);
		b  = mw - (mw >> lv);
		return b[LB_AW-1:0];
	endfunction

	// level takes part in a 2x2 block at this position
	function automatic logic level_active(input logic [LVL_W-1:0] lv,
			input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r, input cfg_t cfg);
		logic [DIM_W-1:0] wn;
		logic [DIM_W-1:0] hn;
		wn = cfg.w >> (lv + LVL_W'(1));
		hn = cfg.h >> (lv + LVL_W'(1));
		return ((lv + LVL_W'(1)) < cfg.levels) &&
			(DIM_W'(c[COL_W-1:1]) < wn) && (DIM_W'(r[ROW_W-1:1]) < hn);
	endfunction

	// four 9-bit lanes, byte of a plus byte of b
	function automatic logic [PSUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [PSUM_W-1:0] s;
		for (int i = 0; i < 4; i++) begin
			s[9*i +: 9] = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
		end
		return s;
	endfunction

	// add two pair-sum rows and drop two bits per lane
	function automatic logic [PIX_W-1:0] quad_avg(input logic [PSUM_W-1:0] top,
			input logic [PSUM_W-1:0] bot);
		logic [PIX_W-1:0] q;
		logic [9:0]       v;
		for (int i = 0; i < 4; i++) begin
			v = {1'b0, top[9*i +: 9]} + {1'b0, bot[9*i +: 9]};
			q[8*i +: 8] = v[9:2];
		end
		return q;
	endfunction

endpackage

`default_nettype wire

[rtl/core/mmbf_line_buf.sv]
// per-level line buffers of horizontal pair sums, color and normal planes
// one write port and one read port, read data registered; uses mmbf_pkg
`default_nettype none

module mmbf_line_buf (
	input  wire                    clk,
	input  mmbf_pkg::lb_req_t      req,
	output logic [mmbf_pkg::PSUM_W-1:0] rd_color,
	output logic [mmbf_pkg::PSUM_W-1:0] rd_normal
);
	import mmbf_pkg::*;

	logic [PSUM_W-1:0] color_mem [0:LB_DEPTH-1];
	logic [PSUM_W-1:0] normal_mem [0:LB_DEPTH-1];
	logic [PSUM_W-1:0] rd_color_q;
	logic [PSUM_W-1:0] rd_normal_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			color_mem[req.addr]  <= req.wdata_c;
			normal_mem[req.addr] <= req.wdata_n;
		end
	end

	// registered read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_color_q  <= color_mem[req.addr];
			rd_normal_q <= normal_mem[req.addr];
		end
	end

	assign rd_color  = rd_color_q;
	assign rd_normal = rd_normal_q;

endmodule

`default_nettype wire

[rtl/core/mmbf_ctrl.sv]
// level sequencer: position counters, held left pixels, averaging and result register
// drives the line buffer through lb_req_t; uses mmbf_pkg
`default_nettype none

module mmbf_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  mmbf_pkg::cfg_t               cfg,
	input  wire                          clr,
	output logic                         idle,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [mmbf_pkg::PIX_W-1:0]   color_pixel,
	input  wire  [mmbf_pkg::PIX_W-1:0]   normal_pixel,
	output mmbf_pkg::lb_req_t            lb_req,
	input  wire  [mmbf_pkg::PSUM_W-1:0]  rd_color,
	input  wire  [mmbf_pkg::PSUM_W-1:0]  rd_normal,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [mmbf_pkg::LVL_W-1:0]   mip_level,
	output logic [mmbf_pkg::POS_W-1:0]   mip_col,
	output logic [mmbf_pkg::POS_W-1:0]   mip_row,
	output logic [mmbf_pkg::PIX_W-1:0]   color_avg,
	output logic [mmbf_pkg::PIX_W-1:0]   normal_avg,
	output logic [mmbf_pkg::LVL_W-1:0]   level_total,
	output logic                         last_of_run
);
	import mmbf_pkg::*;

	ctrl_state_t state_q, state_d;

	logic [LVL_W-1:0]  lvl_q;
	logic [PIX_W-1:0]  pc_q;
	logic [PIX_W-1:0]  pn_q;
	logic [COL_W-1:0]  col_q [0:MAX_LEVELS-1];
	logic [ROW_W-1:0]  row_q [0:MAX_LEVELS-1];
	logic [PIX_W-1:0]  held_c_q [0:MAX_LEVELS-1];
	logic [PIX_W-1:0]  held_n_q [0:MAX_LEVELS-1];

	logic [PSUM_W-1:0] psc_s1;
	logic [PSUM_W-1:0] psn_s1;
	logic [POS_W-1:0]  col_s1;
	logic [POS_W-1:0]  row_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [LVL_W-1:0]  out_lvl_q;
	logic [POS_W-1:0]  out_col_q;
	logic [POS_W-1:0]  out_row_q;
	logic [PIX_W-1:0]  out_c_q;
	logic [PIX_W-1:0]  out_n_q;
	logic [LVL_W-1:0]  out_tot_q;
	logic              out_last_q;

	logic [COL_W-1:0]  c;
	logic [ROW_W-1:0]  r;
	logic [LVL_W-1:0]  lvl_nx;
	logic              active;
	logic              fire;
	logic              nxt_fire;
	logic [PSUM_W-1:0] ps_c;
	logic [PSUM_W-1:0] ps_n;
	logic [COL_W:0]    c_inc;
	logic [ROW_W:0]    r_inc;
	logic [COL_W-1:0]  c_next;
	logic [ROW_W-1:0]  r_next;
	logic [DIM_W-1:0]  wl;
	logic [DIM_W-1:0]  hl;
	logic [PIX_W-1:0]  ac;
	logic [PIX_W-1:0]  an;
	logic              start;
	logic              load;

	// current level decode and lookahead on the level below it
	always_comb begin
		c        = col_q[lvl_q];
		r        = row_q[lvl_q];
		active   = level_active(lvl_q, c, r, cfg);
		fire     = active && c[0] && r[0];
		lvl_nx   = (lvl_q == LVL_W'(MAX_LEVELS - 1)) ? lvl_q : lvl_q + LVL_W'(1);
		nxt_fire = (lvl_q != LVL_W'(MAX_LEVELS - 1)) &&
			level_active(lvl_nx, col_q[lvl_nx], row_q[lvl_nx], cfg) &&
			col_q[lvl_nx][0] && row_q[lvl_nx][0];
		ps_c     = pair_sum(held_c_q[lvl_q], pc_q);
		ps_n     = pair_sum(held_n_q[lvl_q], pn_q);
	end

	// position advance within the level
	always_comb begin
		wl     = cfg.w >> lvl_q;
		hl     = cfg.h >> lvl_q;
		c_inc  = {1'b0, c} + (COL_W + 1)'(1);
		r_inc  = {1'b0, r} + (ROW_W + 1)'(1);
		c_next = c_inc[COL_W-1:0];
		r_next = r;
		if (DIM_W'(c_inc) >= wl) begin
			c_next = '0;
			r_next = (DIM_W'(r_inc) >= hl) ? '0 : r_inc[ROW_W-1:0];
		end
	end

	// line buffer access
	always_comb begin
		lb_req.we      = (state_q == ST_LOOK) && active && c[0] && !r[0];
		lb_req.re      = (state_q == ST_LOOK) && fire;
		lb_req.addr    = lb_base(lvl_q) + LB_AW'(c[COL_W-1:1]);
		lb_req.wdata_c = ps_c;
		lb_req.wdata_n = ps_n;
	end

	// average of the stored top pair and the current bottom pair
	always_comb begin
		ac = quad_avg(rd_color, psc_s1);
		an = quad_avg(rd_normal, psn_s1);
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		load     = 1'b0;
		start    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				start    = in_valid && cfg.rgba;
				if (start) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				in_stall = fire;
				start    = in_valid && !fire && cfg.rgba;
				if (fire) state_d = ST_AVG;
				else if (start) state_d = ST_LOOK;
				else state_d = ST_IDLE;
			end
			ST_AVG: begin
				load = !out_valid_q || !out_stall;
				if (load) state_d = ST_LOOK;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start) lvl_q <= '0;
			else if (load) lvl_q <= lvl_q + LVL_W'(1);
		end
	end

	// position counters, cleared by any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else if (clr) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else if (state_q == ST_LOOK) begin
			col_q[lvl_q] <= c_next;
			row_q[lvl_q] <= r_next;
		end
	end

	// working pixel and held left pixels
	always_ff @(posedge clk) begin
		if (start) begin
			pc_q <= color_pixel;
			pn_q <= normal_pixel;
		end else if (load) begin
			pc_q <= ac;
			pn_q <= an;
		end
		if ((state_q == ST_LOOK) && active && !c[0]) begin
			held_c_q[lvl_q] <= pc_q;
			held_n_q[lvl_q] <= pn_q;
		end
	end

	// averaging stage operands
	always_ff @(posedge clk) begin
		if ((state_q == ST_LOOK) && fire) begin
			psc_s1  <= ps_c;
			psn_s1  <= ps_n;
			col_s1  <= POS_W'(c[COL_W-1:1]);
			row_s1  <= POS_W'(r[ROW_W-1:1]);
			last_s1 <= !nxt_fire;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_lvl_q  <= lvl_q + LVL_W'(1);
			out_col_q  <= col_s1;
			out_row_q  <= row_s1;
			out_c_q    <= ac;
			out_n_q    <= cfg.nrm ? an : '0;
			out_tot_q  <= cfg.levels;
			out_last_q <= last_s1;
		end
	end

	assign idle        = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign mip_level   = out_lvl_q;
	assign mip_col     = out_col_q;
	assign mip_row     = out_row_q;
	assign color_avg   = out_c_q;
	assign normal_avg  = out_n_q;
	assign level_total = out_tot_q;
	assign last_of_run = out_last_q;

	// one line buffer access per cycle
	a_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(lb_req.we && lb_req.re))
		else $error("line buffer read and write in one cycle");

	// a completed block always goes to the averaging step
	a_fire_to_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK && fire) |=> (state_q == ST_AVG))
		else $error("completed block did not reach averaging");

	// last flag lookahead matches what the next level step does
	a_last_lookahead: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AVG && load) |=> (state_q == ST_LOOK && (fire != last_s1)))
		else $error("last flag disagrees with next level");

	// level index stays inside the counter arrays
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (lvl_q < LVL_W'(MAX_LEVELS)))
		else $error("level index out of range");

endmodule

`default_nettype wire

[rtl/core/mipmap_box_filter_2x2_top.sv]
// 2x2 box-filter mip generator: an accepted pixel that completes no mip pixel
// occupies the level sequencer for a single look step, and the next pixel can be taken during that step
// each mip pixel it completes adds a line buffer read step and then an average step; the average
// step waits while the result register is stalled, and the first result is registered by it
// the registered read of the pair-sum line buffer sets the per-level step
// reset: 1024x1024, RGBA on, normals off, position counters zero; line buffers are not cleared
`default_nettype none

module mipmap_box_filter_2x2_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [mmbf_pkg::CIDX_W-1:0]    cfg_index,
	input  wire  [mmbf_pkg::DIM_W-1:0]     cfg_data,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [mmbf_pkg::PIX_W-1:0]     color_pixel,
	input  wire  [mmbf_pkg::PIX_W-1:0]     normal_pixel,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [mmbf_pkg::LVL_W-1:0]     mip_level,
	output logic [mmbf_pkg::POS_W-1:0]     mip_col,
	output logic [mmbf_pkg::POS_W-1:0]     mip_row,
	output logic [mmbf_pkg::PIX_W-1:0]     color_avg,
	output logic [mmbf_pkg::PIX_W-1:0]     normal_avg,
	output logic [mmbf_pkg::LVL_W-1:0]     level_total,
	output logic                           last_of_run
);
	import mmbf_pkg::*;

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic              rgba_q;
	logic              normal_q;
	logic              idle;
	logic              clr;
	cfg_t              cfg;
	lb_req_t           lb_req;
	logic [PSUM_W-1:0] rd_color;
	logic [PSUM_W-1:0] rd_normal;

	assign cfg_ready = idle;

	// register write decode; every known register restarts the image
	always_comb begin
		clr = 1'b0;
		if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_WIDTH, REG_HEIGHT, REG_RGBA, REG_NORMAL: clr = 1'b1;
				default: clr = 1'b0;
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			rgba_q   <= 1'b1;
			normal_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_RGBA:   rgba_q   <= cfg_data[0];
				REG_NORMAL: normal_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective dimensions and level count
	always_comb begin
		cfg.w      = clamp_dim(width_q, DIM_W'(MAX_WIDTH));
		cfg.h      = clamp_dim(height_q, DIM_W'(MAX_HEIGHT));
		cfg.levels = level_count(cfg.w);
		cfg.rgba   = rgba_q;
		cfg.nrm    = normal_q;
	end

	mmbf_line_buf u_line_buf (
		.clk       (clk),
		.req       (lb_req),
		.rd_color  (rd_color),
		.rd_normal (rd_normal)
	);

	mmbf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.clr          (clr),
		.idle         (idle),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.color_pixel  (color_pixel),
		.normal_pixel (normal_pixel),
		.lb_req       (lb_req),
		.rd_color     (rd_color),
		.rd_normal    (rd_normal),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mip_level    (mip_level),
		.mip_col      (mip_col),
		.mip_row      (mip_row),
		.color_avg    (color_avg),
		.normal_avg   (normal_avg),
		.level_total  (level_total),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire

[dv/mip_chain_checker.sv]
// result checker for the 2x2 box-filter mip generator: predicts every mip pixel
// from the observed config and pixel transfers and compares the result channel
// depends on mmbf_pkg for widths, limits and register indexes
`timescale 1ns / 1ps

module mip_chain_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	input  wire                          cfg_ready,
	input  wire [mmbf_pkg::CIDX_W-1:0]   cfg_index,
	input  wire [mmbf_pkg::DIM_W-1:0]    cfg_data,
	input  wire                          in_valid,
	input  wire                          in_stall,
	input  wire [mmbf_pkg::PIX_W-1:0]    color_pixel,
	input  wire [mmbf_pkg::PIX_W-1:0]    normal_pixel,
	input  wire                          out_valid,
	input  wire                          out_stall,
	input  wire [mmbf_pkg::LVL_W-1:0]    mip_level,
	input  wire [mmbf_pkg::POS_W-1:0]    mip_col,
	input  wire [mmbf_pkg::POS_W-1:0]    mip_row,
	input  wire [mmbf_pkg::PIX_W-1:0]    color_avg,
	input  wire [mmbf_pkg::PIX_W-1:0]    normal_avg,
	input  wire [mmbf_pkg::LVL_W-1:0]    level_total,
	input  wire                          last_of_run,
	output int                           fail_count,
	output int                           pending
);
	import mmbf_pkg::*;

	localparam int HALF_SLOTS = MAX_WIDTH / 2 + 1;
	localparam int MAX_RUN    = MAX_LEVELS - 1;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [PIX_W-1:0] color;
		logic [PIX_W-1:0] normal;
		logic [LVL_W-1:0] total;
		logic             last;
	} mip_pixel_t;

	// shadow configuration
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic             rgba_on;
	logic             normal_on;

	// per-level pair sums of the even row, left pixel of the open pair, position
	logic [PSUM_W-1:0] top_sum_c [MAX_LEVELS][HALF_SLOTS];
	logic [PSUM_W-1:0] top_sum_n [MAX_LEVELS][HALF_SLOTS];
	logic [PIX_W-1:0]  left_c [MAX_LEVELS];
	logic [PIX_W-1:0]  left_n [MAX_LEVELS];
	int unsigned       col_pos [MAX_LEVELS];
	int unsigned       row_pos [MAX_LEVELS];

	mip_pixel_t mip_expect [$];
	mip_pixel_t want;
	int         errors;

	// zero and oversize dimensions fold into 1..max
	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] raw, input int unsigned lim);
		int unsigned d;
		d = raw;
		if (d == 0) d = 1;
		if (d > lim) d = lim;
		return d;
	endfunction

	function automatic int unsigned levels_for_width(input int unsigned w);
		int unsigned n;
		n = 1;
		while (n < 31 && (w >> n) != 0) n++;
		if (n > MAX_LEVELS) n = MAX_LEVELS;
		return n;
	endfunction

	// four 9-bit lanes, byte lane of a plus byte lane of b
	function automatic logic [PSUM_W-1:0] add_lanes(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [PSUM_W-1:0] s;
		int unsigned       lane;
		s = '0;
		for (int i = 0; i < 4; i++) begin
			lane = ((a >> (8 * i)) & 32'hFF) + ((b >> (8 * i)) & 32'hFF);
			s = s | (PSUM_W'(lane) << (9 * i));
		end
		return s;
	endfunction

	// sum of two pair-sum rows per lane, truncated by 2
	function automatic logic [PIX_W-1:0] avg_lanes(input logic [PSUM_W-1:0] top,
			input logic [PSUM_W-1:0] bot);
		logic [PIX_W-1:0] q;
		int unsigned      lane;
		q = '0;
		for (int i = 0; i < 4; i++) begin
			lane = 32'((top >> (9 * i)) & 36'h1FF) + 32'((bot >> (9 * i)) & 36'h1FF);
			q = q | (PIX_W'((lane >> 2) & 32'hFF) << (8 * i));
		end
		return q;
	endfunction

	function automatic void restart_image();
		for (int i = 0; i < MAX_LEVELS; i++) begin
			col_pos[i] = 0;
			row_pos[i] = 0;
		end
	endfunction

	// walk the levels depth first for one base pixel, queue what it completes
	task automatic predict_mips(input logic [PIX_W-1:0] color_in, input logic [PIX_W-1:0] normal_in);
		int unsigned       w, h, levels, lv, wl, hl, c, r, r0, half, n;
		logic [PIX_W-1:0]  pc, pn, ac, an;
		logic [PSUM_W-1:0] sc, sn;
		logic              done, stop;
		mip_pixel_t        run [MAX_LEVELS];
		if (!rgba_on) return;
		w = eff_dim(width_reg, MAX_WIDTH);
		h = eff_dim(height_reg, MAX_HEIGHT);
		levels = levels_for_width(w);
		pc = color_in;
		pn = normal_in;
		n = 0;
		stop = 1'b0;
		for (lv = 0; lv < MAX_LEVELS && !stop; lv++) begin
			wl = w >> lv;
			hl = h >> lv;
			c = col_pos[lv];
			r = row_pos[lv];
			r0 = r;
			half = c >> 1;
			done = 1'b0;
			ac = '0;
			an = '0;
			if (lv + 1 < levels && half < (w >> (lv + 1)) && (r >> 1) < (h >> (lv + 1))) begin
				if ((c & 1) == 0) begin
					left_c[lv] = pc;
					left_n[lv] = pn;
				end else begin
					sc = add_lanes(left_c[lv], pc);
					sn = add_lanes(left_n[lv], pn);
					if ((r & 1) == 0) begin
						top_sum_c[lv][half] = sc;
						top_sum_n[lv][half] = sn;
					end else begin
						ac = avg_lanes(top_sum_c[lv][half], sc);
						an = avg_lanes(top_sum_n[lv][half], sn);
						done = 1'b1;
					end
				end
			end
			// advance this level, wrapping into a new image at the end
			c++;
			if (c >= wl) begin
				c = 0;
				r++;
				if (r >= hl) r = 0;
			end
			col_pos[lv] = c;
			row_pos[lv] = r;
			if (!done || n >= MAX_RUN) begin
				stop = 1'b1;
			end else begin
				// row of the finished block is the odd row it closed, halved
				run[n].level  = LVL_W'(lv + 1);
				run[n].col    = POS_W'(half);
				run[n].row    = POS_W'(r0 >> 1);
				run[n].color  = ac;
				run[n].normal = normal_on ? an : '0;
				run[n].total  = LVL_W'(levels);
				run[n].last   = 1'b0;
				n++;
				pc = ac;
				pn = an;
			end
		end
		if (n > 0) begin
			run[n - 1].last = 1'b1;
			for (int k = 0; k < n; k++) mip_expect.push_back(run[k]);
		end
	endtask

	task automatic check_field(input string name, input logic [PIX_W-1:0] exp_v,
			input logic [PIX_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			rgba_on = 1'b1;
			normal_on = 1'b0;
			restart_image();
			mip_expect.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// config transfer: shadow the register, a new image begins
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_WIDTH:  width_reg = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					REG_RGBA:   rgba_on = cfg_data[0];
					REG_NORMAL: normal_on = cfg_data[0];
					default: ;
				endcase
				restart_image();
			end
			// pixel transfer
			if (in_valid && !in_stall) predict_mips(color_pixel, normal_pixel);
			// result transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				if (mip_expect.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual level %0d col %0d row %0d",
						$time, mip_level, mip_col, mip_row);
					errors++;
				end else begin
					want = mip_expect.pop_front();
					check_field("mip_level", PIX_W'(want.level), PIX_W'(mip_level));
					check_field("mip_col", PIX_W'(want.col), PIX_W'(mip_col));
					check_field("mip_row", PIX_W'(want.row), PIX_W'(mip_row));
					check_field("color_avg", want.color, color_avg);
					check_field("normal_avg", want.normal, normal_avg);
					check_field("level_total", PIX_W'(want.total), PIX_W'(level_total));
					check_field("last_of_run", PIX_W'(want.last), PIX_W'(last_of_run));
				end
			end
			fail_count <= errors;
			pending <= mip_expect.size();
		end
	end

endmodule

[dv/tb_mipmap_box_filter_2x2_top.sv]
// testbench top for mipmap_box_filter_2x2_top: drives config and pixel streams
// under several idle patterns; mip_chain_checker predicts and compares results
// depends on mmbf_pkg, the block and mip_chain_checker
`timescale 1ns / 1ps

module tb_mipmap_box_filter_2x2_top;
	import mmbf_pkg::*;

	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 32;
	localparam int RANDOM_ITEMS  = 140;
	localparam int TIMEOUT_NS    = 2_000_000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic [PIX_W-1:0]  color_pixel = '0;
	logic [PIX_W-1:0]  normal_pixel = '0;
	logic              out_stall = 1'b0;

	wire               cfg_ready;
	wire               in_stall;
	wire               out_valid;
	wire [LVL_W-1:0]   mip_level;
	wire [POS_W-1:0]   mip_col;
	wire [POS_W-1:0]   mip_row;
	wire [PIX_W-1:0]   color_avg;
	wire [PIX_W-1:0]   normal_avg;
	wire [LVL_W-1:0]   level_total;
	wire               last_of_run;

	int fail_count;
	int pending;
	int send_gap_pct = 0;
	int stall_pct = 0;

	mipmap_box_filter_2x2_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.color_pixel  (color_pixel),
		.normal_pixel (normal_pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mip_level    (mip_level),
		.mip_col      (mip_col),
		.mip_row      (mip_row),
		.color_avg    (color_avg),
		.normal_avg   (normal_avg),
		.level_total  (level_total),
		.last_of_run  (last_of_run)
	);

	mip_chain_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.color_pixel  (color_pixel),
		.normal_pixel (normal_pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mip_level    (mip_level),
		.mip_col      (mip_col),
		.mip_row      (mip_row),
		.color_avg    (color_avg),
		.normal_avg   (normal_avg),
		.level_total  (level_total),
		.last_of_run  (last_of_run),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always #1 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// hard stop if the run hangs
	initial begin
		#(TIMEOUT_NS);
		$display("tb_mipmap_box_filter_2x2_top: errors");
		$finish;
	end

	task automatic set_idle(input idle_mode_t m);
		case (m)
			IDLE_NONE:     begin send_gap_pct <= 0;  stall_pct <= 0;  end
			IDLE_SENDER:   begin send_gap_pct <= 79; stall_pct <= 0;  end
			IDLE_RECEIVER: begin send_gap_pct <= 0;  stall_pct <= 79; end
			default:       begin send_gap_pct <= 34; stall_pct <= 34; end
		endcase
	endtask

	// random pixel, biased toward all-zero and all-one byte lanes
	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [PIX_W-1:0] v;
		v = $urandom;
		case ($urandom_range(7))
			0: v = '0;
			1: v = '1;
			2: for (int i = 0; i < 4; i++) v[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
			default: ;
		endcase
		return v;
	endfunction

	// one pixel transfer, with random sender gaps in front
	task automatic send_pixel(input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] n);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		color_pixel <= c;
		normal_pixel <= n;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop sending, wait for every predicted result, then let the sequencer go quiet
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(input int unsigned w, input int unsigned h, input bit rgba,
			input bit nrm);
		drain();
		write_reg(REG_WIDTH, DIM_W'(w));
		write_reg(REG_HEIGHT, DIM_W'(h));
		write_reg(REG_RGBA, DIM_W'(rgba));
		write_reg(REG_NORMAL, DIM_W'(nrm));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned w, h, count;
		bit          rgba, nrm;
		int          job;
		int          counted_items;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 2x2 image, saturating lanes and truncation
		set_idle(IDLE_NONE);
		configure(2, 2, 1'b1, 1'b1);
		send_pixel(32'hFFFFFFFF, 32'h00000000);
		send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
		send_pixel(32'hFFFFFFFF, 32'h00FF00FF);
		send_pixel(32'h00000000, 32'hFF00FF00);

		// directed: 4x4 cascades level 1 into level 2
		configure(4, 4, 1'b1, 1'b1);
		for (int i = 0; i < 16; i++) send_pixel({4{8'(i * 17)}}, ~{4{8'(i * 17)}});

		// directed: rgba off ignores pixels
		configure(4, 4, 1'b0, 1'b0);
		send_pixel(32'h12345678, 32'h9ABCDEF0);
		send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);

		// directed: zero dimensions read as 1x1
		configure(0, 0, 1'b1, 1'b0);
		send_pixel(32'hA5A5A5A5, 32'h5A5A5A5A);

		// directed: oversize dimensions saturate, image cut short by the next write
		configure(2047, 2047, 1'b1, 1'b1);
		send_pixel(32'h0F0F0F0F, 32'hF0F0F0F0);
		send_pixel(32'hF0F0F0F0, 32'h0F0F0F0F);

		// random images, idle pattern rotating per image
		job = 0;
		counted_items = 0;
		while (counted_items < RANDOM_ITEMS) begin
			set_idle(idle_mode_t'(job % 4));
			w = ($urandom_range(4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
			h = ($urandom_range(4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
			rgba = ($urandom_range(9) != 0);
			nrm = $urandom_range(1);
			configure(w, h, rgba, nrm);
			// whole images, sometimes followed by a partial one
			count = $urandom_range(1, 2) * w * h;
			if ($urandom_range(3) == 0) count += $urandom_range(1, w * h);
			repeat (count) send_pixel(rand_pixel(), rand_pixel());
			counted_items += count;
			job++;
		end

		// wide image: long level 1 row and its last column
		set_idle(IDLE_SENDER);
		configure(64, 2, 1'b1, 1'b1);
		repeat (128) send_pixel(rand_pixel(), rand_pixel());

		// tall image: many level 1 rows and the last one
		set_idle(IDLE_BOTH);
		configure(2, 64, 1'b1, 1'b0);
		repeat (128) send_pixel(rand_pixel(), rand_pixel());

		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("tb_mipmap_box_filter_2x2_top: clean");
		end else begin
			$display("tb_mipmap_box_filter_2x2_top: errors");
		end
		$finish;
	end

endmodule
